// ===== rtl/bsf_pkg.sv =====
// Shared types and constants for the binaural stereo FIR block.
package bsf_pkg;

	// Data widths fixed by the interface
	localparam int DATA_W       = 16;
	localparam int TAP_IDX_W    = 6;
	localparam int TAP_COUNT_W  = 7;
	localparam int PROD_W       = 2 * DATA_W;
	localparam int MAX_TAPS_DEF = 64;

	// Configuration port
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic [APB_ADDR_W-3:0] REG_TAP_COUNT = '0;
	localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RST = 7'd64;

	// Command codes
	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_FILTER = 1'b1;

	// Rounding: add half an LSB of Q1.15 before dropping 14 fraction bits
	localparam int RND_SHIFT = 14;
	localparam int RND_HALF  = 8192;
	localparam int SAT_MAX   = 32767;
	localparam int SAT_MIN   = -32768;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FLUSH,
		ST_FINISH
	} state_t;

	// Per-cycle control of the cell chain
	typedef struct packed {
		logic shift;   // push a new sample into the delay line
		logic rotate;  // rotate samples and taps one cell toward cell 0
	} cell_ctrl_t;

	// Per-cycle control of a multiply-accumulate unit
	typedef struct packed {
		logic clear;   // start a new sum
		logic en;      // product of this cycle counts toward the sum
	} mac_ctrl_t;

endpackage

// ===== rtl/bsf_cell.sv =====
// One cell of the delay line: a history sample plus the left and right tap.
module bsf_cell (
	input  logic                              clk,
	input  logic                              arst_n,
	input  bsf_pkg::cell_ctrl_t               ctrl,
	input  logic signed [bsf_pkg::DATA_W-1:0] x_shift,
	input  logic signed [bsf_pkg::DATA_W-1:0] x_rot,
	input  logic signed [bsf_pkg::DATA_W-1:0] hl_rot,
	input  logic signed [bsf_pkg::DATA_W-1:0] hr_rot,
	input  logic                              tap_we,
	input  logic signed [bsf_pkg::DATA_W-1:0] tap_l,
	input  logic signed [bsf_pkg::DATA_W-1:0] tap_r,
	output logic signed [bsf_pkg::DATA_W-1:0] x,
	output logic signed [bsf_pkg::DATA_W-1:0] hl,
	output logic signed [bsf_pkg::DATA_W-1:0] hr
);

	logic signed [bsf_pkg::DATA_W-1:0] x_q;
	logic signed [bsf_pkg::DATA_W-1:0] hl_q;
	logic signed [bsf_pkg::DATA_W-1:0] hr_q;

	// History sample: shifted on a new sample, rotated during the sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0;
		end else if (ctrl.shift) begin
			x_q <= x_shift;
		end else if (ctrl.rotate) begin
			x_q <= x_rot;
		end
	end

	// Tap pair: written by a load, rotated together with the history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hl_q <= '0;
			hr_q <= '0;
		end else if (tap_we) begin
			hl_q <= tap_l;
			hr_q <= tap_r;
		end else if (ctrl.rotate) begin
			hl_q <= hl_rot;
			hr_q <= hr_rot;
		end
	end

	assign x  = x_q;
	assign hl = hl_q;
	assign hr = hr_q;

endmodule

// ===== rtl/bsf_mac.sv =====
// Multiply-accumulate for one ear, with rounding and saturation to Q1.15.
module bsf_mac #(
	parameter int ACC_W = 38
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  bsf_pkg::mac_ctrl_t                ctrl,
	input  logic signed [bsf_pkg::DATA_W-1:0] x,
	input  logic signed [bsf_pkg::DATA_W-1:0] h,
	output logic signed [bsf_pkg::DATA_W-1:0] y,
	output logic                              clip
);

	localparam int RND_W = ACC_W + 1;

	logic signed [bsf_pkg::PROD_W-1:0] prod_s1;
	logic                              en_s1;
	logic signed [ACC_W-1:0]           acc_q;
	logic signed [RND_W-1:0]           rnd;
	logic signed [RND_W-1:0]           shr;
	logic                              over;
	logic                              under;

	// Product stage
	always_ff @(posedge clk) begin
		prod_s1 <= bsf_pkg::PROD_W'(x) * bsf_pkg::PROD_W'(h);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_s1 <= 1'b0;
		end else begin
			en_s1 <= ctrl.en;
		end
	end

	// Accumulator; clear and the last product of a previous sum never coincide
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctrl.clear) begin
			acc_q <= '0;
		end else if (en_s1) begin
			acc_q <= acc_q + ACC_W'(prod_s1);
		end
	end

	// Round half up, floor shift, saturate
	always_comb begin
		rnd   = RND_W'(acc_q) + RND_W'(bsf_pkg::RND_HALF);
		shr   = rnd >>> bsf_pkg::RND_SHIFT;
		over  = shr > RND_W'(bsf_pkg::SAT_MAX);
		under = shr < RND_W'(bsf_pkg::SAT_MIN);
		if (over) begin
			y = bsf_pkg::DATA_W'(bsf_pkg::SAT_MAX);
		end else if (under) begin
			y = bsf_pkg::DATA_W'(bsf_pkg::SAT_MIN);
		end else begin
			y = shr[bsf_pkg::DATA_W-1:0];
		end
		clip = over | under;
	end

endmodule

// ===== rtl/binaural_stereo_fir.sv =====
// Binaural stereo FIR: mono Q1.15 in, left/right Q1.15 out via a rotating cell chain.
//
// Input channel (in_valid/in_ready): cmd selects a tap load or a sample.
// A load writes tap pair tap_index and gives no result; indexes of
// MAX_TAPS and above are dropped. A sample (block_start optionally
// clearing the history first) is shifted into the delay line and gives
// one transaction on the output channel (out_valid/out_ready).
// Each sample passes from acceptance to a loaded output register
// through the RUN, FLUSH and FINISH states: the history and tap cells
// rotate once around the chain, one tap per cycle through a single
// multiplier per ear, then an accumulate flush for the last product and
// the output load. The next item is accepted in the cycle after the
// output load; a sample may follow while a result still waits for
// out_ready, and a stalled receiver holds the block only if a second
// result is ready.
// tap_count is set through the APB port at byte address 0; the user must
// write it only while idle, which the block does not enforce. Reset clears
// history, taps and out_valid, sets tap_count to 64, and leaves the block idle and ready for items.
module binaural_stereo_fir #(
	parameter int MAX_TAPS = bsf_pkg::MAX_TAPS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// Item input
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  cmd,
	input  logic [bsf_pkg::TAP_IDX_W-1:0]         tap_index,
	input  logic signed [bsf_pkg::DATA_W-1:0]     tap_left,
	input  logic signed [bsf_pkg::DATA_W-1:0]     tap_right,
	input  logic signed [bsf_pkg::DATA_W-1:0]     sample_in,
	input  logic                                  block_start,
	// Result output
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [bsf_pkg::DATA_W-1:0]     left_out,
	output logic signed [bsf_pkg::DATA_W-1:0]     right_out,
	output logic                                  clipped,
	// Configuration
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [bsf_pkg::APB_ADDR_W-1:0]        paddr,
	input  logic [bsf_pkg::APB_DATA_W-1:0]        pwdata,
	output logic [bsf_pkg::APB_DATA_W-1:0]        prdata,
	output logic                                  pready
);

	localparam int CNT_W = $clog2(MAX_TAPS + 1);
	localparam int CMP_W = (CNT_W > bsf_pkg::TAP_COUNT_W) ? CNT_W : bsf_pkg::TAP_COUNT_W;
	localparam int ACC_W = bsf_pkg::PROD_W + $clog2(MAX_TAPS);

	bsf_pkg::state_t state_q, state_nxt;

	logic [bsf_pkg::TAP_COUNT_W-1:0] tap_count_q;
	logic [CNT_W-1:0]                cnt_q;
	logic [CMP_W-1:0]                tc_ext;
	logic [CMP_W-1:0]                n_eff;
	logic                            in_acc;
	logic                            smp_acc;
	logic                            load_acc;
	logic                            last_tap;
	logic                            out_load;
	logic                            cfg_wr;

	bsf_pkg::cell_ctrl_t cell_ctrl;
	bsf_pkg::mac_ctrl_t  mac_ctrl;

	logic signed [bsf_pkg::DATA_W-1:0] x_c  [MAX_TAPS];
	logic signed [bsf_pkg::DATA_W-1:0] hl_c [MAX_TAPS];
	logic signed [bsf_pkg::DATA_W-1:0] hr_c [MAX_TAPS];

	logic signed [bsf_pkg::DATA_W-1:0] y_l;
	logic signed [bsf_pkg::DATA_W-1:0] y_r;
	logic                              clip_l;
	logic                              clip_r;

	logic                              out_valid_q;
	logic signed [bsf_pkg::DATA_W-1:0] left_q;
	logic signed [bsf_pkg::DATA_W-1:0] right_q;
	logic                              clipped_q;

	// Configuration register
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= bsf_pkg::TAP_COUNT_RST;
		end else if (cfg_wr && paddr[bsf_pkg::APB_ADDR_W-1:2] == bsf_pkg::REG_TAP_COUNT) begin
			tap_count_q <= pwdata[bsf_pkg::TAP_COUNT_W-1:0];
		end
	end

	always_comb begin
		unique case (paddr[bsf_pkg::APB_ADDR_W-1:2])
			bsf_pkg::REG_TAP_COUNT: prdata = bsf_pkg::APB_DATA_W'(tap_count_q);
			default:                prdata = '0;
		endcase
	end

	// Handshake decode
	assign in_acc   = in_valid & in_ready;
	assign smp_acc  = in_acc & (cmd == bsf_pkg::CMD_FILTER);
	assign load_acc = in_acc & (cmd == bsf_pkg::CMD_LOAD);
	assign last_tap = cnt_q == CNT_W'(MAX_TAPS - 1);

	// Taps in use, limited to the chain length
	assign tc_ext = CMP_W'(tap_count_q);
	assign n_eff  = (tc_ext > CMP_W'(MAX_TAPS)) ? CMP_W'(MAX_TAPS) : tc_ext;

	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bsf_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			bsf_pkg::ST_IDLE:   if (smp_acc) state_nxt = bsf_pkg::ST_RUN;
			bsf_pkg::ST_RUN:    if (last_tap) state_nxt = bsf_pkg::ST_FLUSH;
			bsf_pkg::ST_FLUSH:  state_nxt = bsf_pkg::ST_FINISH;
			bsf_pkg::ST_FINISH: if (!out_valid_q || out_ready) state_nxt = bsf_pkg::ST_IDLE;
			default:            state_nxt = bsf_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		in_ready         = 1'b0;
		cell_ctrl.shift  = 1'b0;
		cell_ctrl.rotate = 1'b0;
		mac_ctrl.clear   = 1'b0;
		mac_ctrl.en      = 1'b0;
		out_load         = 1'b0;
		unique case (state_q)
			bsf_pkg::ST_IDLE: begin
				in_ready        = 1'b1;
				cell_ctrl.shift = smp_acc;
				mac_ctrl.clear  = smp_acc;
			end
			bsf_pkg::ST_RUN: begin
				cell_ctrl.rotate = 1'b1;
				mac_ctrl.en      = CMP_W'(cnt_q) < n_eff;
			end
			bsf_pkg::ST_FLUSH: begin
			end
			bsf_pkg::ST_FINISH: begin
				out_load = !out_valid_q || out_ready;
			end
			default: begin
			end
		endcase
	end

	// Tap counter for the rotation pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (smp_acc) begin
			cnt_q <= '0;
		end else if (state_q == bsf_pkg::ST_RUN) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	// Cell chain: cell k holds x[n-k] and tap k; rotation feeds cell 0 to the MACs
	for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
		logic signed [bsf_pkg::DATA_W-1:0] x_in;
		logic                              we;

		if (k == 0) begin : g_head
			assign x_in = sample_in;
		end else begin : g_body
			assign x_in = block_start ? '0 : x_c[k-1];
		end

		assign we = load_acc && (32'(tap_index) == k);

		bsf_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl    (cell_ctrl),
			.x_shift (x_in),
			.x_rot   (x_c[(k + 1) % MAX_TAPS]),
			.hl_rot  (hl_c[(k + 1) % MAX_TAPS]),
			.hr_rot  (hr_c[(k + 1) % MAX_TAPS]),
			.tap_we  (we),
			.tap_l   (tap_left),
			.tap_r   (tap_right),
			.x       (x_c[k]),
			.hl      (hl_c[k]),
			.hr      (hr_c[k])
		);
	end

	// One MAC per ear at the head of the chain
	bsf_mac #(.ACC_W(ACC_W)) u_mac_l (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mac_ctrl),
		.x      (x_c[0]),
		.h      (hl_c[0]),
		.y      (y_l),
		.clip   (clip_l)
	);

	bsf_mac #(.ACC_W(ACC_W)) u_mac_r (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mac_ctrl),
		.x      (x_c[0]),
		.h      (hr_c[0]),
		.y      (y_r),
		.clip   (clip_r)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			left_q    <= y_l;
			right_q   <= y_r;
			clipped_q <= clip_l | clip_r;
		end
	end

	assign out_valid = out_valid_q;
	assign left_out  = left_q;
	assign right_out = right_q;
	assign clipped   = clipped_q;

endmodule

// ===== rtl/bsf_checker.sv =====
// Port-level checks for the binaural stereo FIR, bound to the top level.
module bsf_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic                              cmd,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic signed [bsf_pkg::DATA_W-1:0] left_out,
	input logic signed [bsf_pkg::DATA_W-1:0] right_out,
	input logic                              clipped
);

	// A stalled result holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(left_out) && $stable(right_out)
			&& $stable(clipped))
		else $error("result changed while stalled");

	// A sample transaction occupies the block for the next cycle
	a_busy_after_sample: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && cmd == bsf_pkg::CMD_FILTER |=> !in_ready)
		else $error("input accepted during a filter pass");

	// A tap load never produces a result
	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && cmd == bsf_pkg::CMD_LOAD && !out_valid |=> !out_valid)
		else $error("result appeared after a tap load");

	// A clip flag comes with at least one output at a rail
	a_clip_rail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && clipped |->
			left_out == 16'sh7fff || left_out == -16'sh8000
			|| right_out == 16'sh7fff || right_out == -16'sh8000)
		else $error("clip flag without a saturated output");

endmodule

bind binaural_stereo_fir bsf_checker u_bsf_checker (.*);

// ===== bench/binaural_stereo_fir_test.sv =====
// Self-checking testbench for the binaural stereo FIR block.
module binaural_stereo_fir_test;
	import bsf_pkg::*;

	localparam int HIST_DEPTH   = MAX_TAPS_DEF;
	localparam int DRAIN_CYCLES = MAX_TAPS_DEF + 16;  // one sample's latency plus margin
	localparam int QUIET_LIMIT  = 4000;
	localparam int PRINT_LIMIT  = 50;

	typedef struct {
		logic                     op;
		logic [TAP_IDX_W-1:0]     index;
		logic signed [DATA_W-1:0] coef_l;
		logic signed [DATA_W-1:0] coef_r;
		logic signed [DATA_W-1:0] sample;
		logic                     restart;
	} fir_item_t;

	typedef struct {
		logic signed [DATA_W-1:0] left_smp;
		logic signed [DATA_W-1:0] right_smp;
		logic                     clip;
	} stereo_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid, in_ready;
	logic cmd;
	logic [TAP_IDX_W-1:0] tap_index;
	logic signed [DATA_W-1:0] tap_left, tap_right, sample_in;
	logic block_start;
	logic out_valid, out_ready;
	logic signed [DATA_W-1:0] left_out, right_out;
	logic clipped;
	logic psel, penable, pwrite, pready;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata, prdata;

	// Predictor state
	logic signed [DATA_W-1:0] delay_line [HIST_DEPTH];
	logic signed [DATA_W-1:0] left_coef [HIST_DEPTH];
	logic signed [DATA_W-1:0] right_coef [HIST_DEPTH];
	int unsigned              write_pos;
	logic [TAP_COUNT_W-1:0]   active_taps;

	stereo_t expected_stereo[$];
	int mismatches = 0;
	int quiet_cycles = 0;
	int sender_idle_pct = 0;
	int receiver_idle_pct = 0;
	int hold_off = 0;

	binaural_stereo_fir i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.cmd(cmd), .tap_index(tap_index), .tap_left(tap_left), .tap_right(tap_right),
		.sample_in(sample_in), .block_start(block_start),
		.out_valid(out_valid), .out_ready(out_ready),
		.left_out(left_out), .right_out(right_out), .clipped(clipped),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= PRINT_LIMIT)
			$display("MISMATCH at %0t: %s", $time, msg);
	endtask

	// Round Q3.29 sum to Q1.15, halves up; bit 16 flags saturation
	function automatic logic [DATA_W:0] round_q15(input longint acc);
		longint r;
		r = (acc + RND_HALF) >>> RND_SHIFT;
		if (r > SAT_MAX)
			return {1'b1, 16'h7FFF};
		if (r < SAT_MIN)
			return {1'b1, 16'h8000};
		return {1'b0, r[DATA_W-1:0]};
	endfunction

	function automatic void store_tap_pair(input fir_item_t it);
		left_coef[it.index] = it.coef_l;
		right_coef[it.index] = it.coef_r;
	endfunction

	// Push one sample into the delay line and compute both ears
	function automatic stereo_t filter_sample(input fir_item_t it);
		longint acc_l, acc_r;
		int n, pos;
		logic [DATA_W:0] rl, rr;
		stereo_t res;
		if (it.restart) begin
			foreach (delay_line[i]) delay_line[i] = '0;
			write_pos = 0;
		end
		delay_line[write_pos] = it.sample;
		n = (active_taps > HIST_DEPTH) ? HIST_DEPTH : int'(active_taps);
		acc_l = 0;
		acc_r = 0;
		for (int k = 0; k < n; k++) begin
			pos = (write_pos + HIST_DEPTH - k) % HIST_DEPTH;
			acc_l += longint'(delay_line[pos]) * longint'(left_coef[k]);
			acc_r += longint'(delay_line[pos]) * longint'(right_coef[k]);
		end
		write_pos = (write_pos + 1) % HIST_DEPTH;
		rl = round_q15(acc_l);
		rr = round_q15(acc_r);
		res.left_smp = rl[DATA_W-1:0];
		res.right_smp = rr[DATA_W-1:0];
		res.clip = rl[DATA_W] | rr[DATA_W];
		return res;
	endfunction

	// Send one transaction, with optional idle gap before it
	task automatic issue_item(input fir_item_t it);
		int gap;
		@(negedge clk);
		if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			gap = ($urandom_range(19) == 0) ? $urandom_range(80, 1) : $urandom_range(4, 1);
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		cmd <= it.op;
		tap_index <= it.index;
		tap_left <= it.coef_l;
		tap_right <= it.coef_r;
		sample_in <= it.sample;
		block_start <= it.restart;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (it.op == CMD_FILTER)
			expected_stereo.push_back(filter_sample(it));
		else
			store_tap_pair(it);
	endtask

	task automatic drop_valid();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	function automatic logic signed [DATA_W-1:0] rand_q15();
		case ($urandom_range(9))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2, 3: return DATA_W'($urandom_range(1023) - 512);
			default: return DATA_W'($urandom);
		endcase
	endfunction

	function automatic logic signed [DATA_W-1:0] rand_coef();
		if ($urandom_range(1) == 0)
			return DATA_W'($urandom_range(1023) - 512);
		return rand_q15();
	endfunction

	task automatic load_tap(input logic [TAP_IDX_W-1:0] idx,
			input logic signed [DATA_W-1:0] cl, input logic signed [DATA_W-1:0] cr);
		fir_item_t it;
		it.op = CMD_LOAD;
		it.index = idx;
		it.coef_l = cl;
		it.coef_r = cr;
		it.sample = DATA_W'($urandom);  // ignored on a load
		it.restart = 1'($urandom_range(1));
		issue_item(it);
	endtask

	task automatic play_sample(input logic signed [DATA_W-1:0] x, input logic restart);
		fir_item_t it;
		it.op = CMD_FILTER;
		it.index = TAP_IDX_W'($urandom);  // tap fields ignored on a sample
		it.coef_l = DATA_W'($urandom);
		it.coef_r = DATA_W'($urandom);
		it.sample = x;
		it.restart = restart;
		issue_item(it);
	endtask

	// Idle the block, then write tap_count and read it back
	task automatic set_tap_count(input logic [TAP_COUNT_W-1:0] value);
		logic [APB_DATA_W-1:0] word;
		drop_valid();
		while (expected_stereo.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		word = $urandom;
		word[TAP_COUNT_W-1:0] = value;
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {REG_TAP_COUNT, 2'b00};
		pwdata <= word;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		active_taps = value;
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== APB_DATA_W'(value))
			report_mismatch($sformatf("tap_count read %0h, wrote %0h", prdata, value));
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Mostly tap reloads followed by sample runs; some stray items
	task automatic play_random_passage(input int count);
		int left_items, n, run_len;
		left_items = count;
		while (left_items > 0) begin
			if ($urandom_range(9) < 8) begin
				n = $urandom_range(6, 1);
				for (int i = 0; i < n && left_items > 0; i++) begin
					load_tap(TAP_IDX_W'($urandom), rand_coef(), rand_coef());
					left_items--;
				end
				run_len = ($urandom_range(9) == 0) ? $urandom_range(100, 64)
						: $urandom_range(24, 4);
				for (int i = 0; i < run_len && left_items > 0; i++) begin
					play_sample(rand_q15(), (i == 0) ? ($urandom_range(2) == 0)
							: ($urandom_range(32) == 0));
					left_items--;
				end
			end else begin
				if ($urandom_range(1) == 0)
					load_tap(TAP_IDX_W'($urandom), rand_q15(), rand_q15());
				else
					play_sample(rand_q15(), 1'($urandom_range(1)));
				left_items--;
			end
		end
	endtask

	// Field extremes, saturation both ways, rounding of halves
	task automatic test_directed();
		play_sample(16'sh7FFF, 1'b1);
		load_tap(6'd0, 16'sh4000, 16'sh8000);
		load_tap(6'd63, 16'sh7FFF, 16'sh8000);
		play_sample(16'sh7FFF, 1'b1);
		play_sample(16'sh8000, 1'b0);
		load_tap(6'd1, 16'sh4000, 16'sh4000);
		play_sample(16'sd100, 1'b0);
		load_tap(6'd0, 16'sd1, -16'sd1);
		load_tap(6'd1, 16'sd0, 16'sd0);
		play_sample(16'sd8192, 1'b1);
		play_sample(-16'sd8192, 1'b1);
		play_sample(16'sd8191, 1'b1);
		play_sample(-16'sd8193, 1'b1);
		play_sample(16'sd3, 1'b0);
	endtask

	// Single tap, empty sum, above the store, and ordinary counts
	task automatic test_tap_counts();
		logic [TAP_COUNT_W-1:0] counts [7];
		counts = '{7'd1, 7'd0, 7'd127, 7'd65, 7'd64, 7'd2, TAP_COUNT_W'($urandom_range(63, 3))};
		foreach (counts[i]) begin
			set_tap_count(counts[i]);
			play_random_passage(50);
		end
	endtask

	task automatic test_idle_modes();
		sender_idle_pct = 25;
		receiver_idle_pct = 64;
		set_tap_count(TAP_COUNT_W'($urandom_range(64, 1)));
		play_random_passage(400);
		sender_idle_pct = 64;
		receiver_idle_pct = 25;
		set_tap_count(TAP_COUNT_W'($urandom_range(64, 1)));
		play_random_passage(400);
		sender_idle_pct = 0;
		receiver_idle_pct = 0;
		set_tap_count(TAP_COUNT_W'($urandom_range(64, 1)));
		play_random_passage(400);
	endtask

	// Receiver holds off long enough for the block to fill and stall
	task automatic test_backpressure();
		set_tap_count(7'd64);
		hold_off = 600;
		for (int i = 0; i < 40; i++)
			play_sample(rand_q15(), (i == 0));
	endtask

	// Receiver: random stalls plus requested hold-off
	always @(negedge clk) begin
		if (hold_off > 0) begin
			out_ready <= 1'b0;
			hold_off = hold_off - 1;
		end else begin
			out_ready <= ($urandom_range(99) >= receiver_idle_pct);
		end
	end

	// Compare each result transaction with the oldest expectation
	always @(posedge clk) begin
		stereo_t exp_r;
		if (arst_n && out_valid && out_ready) begin
			if (expected_stereo.size() == 0) begin
				report_mismatch("result with nothing expected");
			end else begin
				exp_r = expected_stereo.pop_front();
				if (left_out !== exp_r.left_smp)
					report_mismatch($sformatf("left_out %0d, expected %0d",
							left_out, exp_r.left_smp));
				if (right_out !== exp_r.right_smp)
					report_mismatch($sformatf("right_out %0d, expected %0d",
							right_out, exp_r.right_smp));
				if (clipped !== exp_r.clip)
					report_mismatch($sformatf("clipped %0b, expected %0b",
							clipped, exp_r.clip));
			end
		end
	end

	// Watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles = quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("TIMEOUT: no transaction for %0d cycles", QUIET_LIMIT);
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		cmd = CMD_LOAD;
		tap_index = '0;
		tap_left = '0;
		tap_right = '0;
		sample_in = '0;
		block_start = 1'b0;
		out_ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		foreach (delay_line[i]) begin
			delay_line[i] = '0;
			left_coef[i] = '0;
			right_coef[i] = '0;
		end
		write_pos = 0;
		active_taps = TAP_COUNT_RST;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		sender_idle_pct = 25;
		receiver_idle_pct = 64;
		test_directed();
		test_tap_counts();
		test_idle_modes();
		test_backpressure();

		drop_valid();
		while (expected_stereo.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
